@@ hdl/rspc_pkg.sv @@
`default_nettype none

package rspc_pkg;

   localparam int TICKS_PER_SEC_DEF = 16000;

   localparam int FUNC_W     = 3;
   localparam int TIME_W     = 32;
   localparam int SPEED_W    = 16;
   localparam int FREQ_W     = 30;
   localparam int DEN_W      = SPEED_W + FREQ_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [FREQ_W-1:0] SRC_FREQ_RST     = FREQ_W'(1000);
   localparam logic [TIME_W-1:0] BENCH_MARKER_RST = '1;

   localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SET_TIME  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SET_SPEED = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SET_PLAY  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_FREQ  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BENCH_MARKER = 1'd1;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [TIME_W-1:0] time_value;
      logic                     play_value;
      logic [SPEED_W-1:0]       speed_num;
      logic [SPEED_W-1:0]       speed_den;
   } req_type;

   typedef struct packed {
      logic signed [TIME_W-1:0] now_time;
      logic                     play_state;
      logic [SPEED_W-1:0]       cur_speed_num;
      logic [SPEED_W-1:0]       cur_speed_den;
      logic                     status;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/rspc_muldiv.sv @@
`default_nettype none

module rspc_muldiv #(
   parameter int NUM_W = 30
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [rspc_pkg::TIME_W-1:0] ticks,
   input  wire logic [NUM_W-1:0]           num,
   input  wire logic [rspc_pkg::DEN_W-1:0] den,
   output      logic                       busy,
   output      logic                       done,
   output      logic [rspc_pkg::TIME_W-1:0] quot
);
   import rspc_pkg::*;

   localparam int PROD_W = TIME_W + NUM_W;
   localparam int CNT_W  = $clog2(PROD_W);

   typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV} ustate_type;

   ustate_type          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic                done_ff, done_in;

   logic [NUM_W:0]      sum;
   logic [DEN_W:0]      shifted;
   logic [DEN_W:0]      diff;
   logic                ge;

   always_comb begin
      sum     = {1'b0, prod_ff[PROD_W-1:TIME_W]} + (prod_ff[0] ? {1'b0, num_ff} : '0);
      shifted = {rem_ff, prod_ff[PROD_W-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};

      state_in = state_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;

      case (state_ff)
         U_IDLE: begin
            if (start) begin
               prod_in  = {{NUM_W{1'b0}}, ticks};
               num_in   = num;
               den_in   = den;
               cnt_in   = CNT_W'(TIME_W - 1);
               state_in = U_MUL;
            end
         end
         U_MUL: begin
            // add the multiplicand on a set low bit, shift the product right
            prod_in = {sum, prod_ff[TIME_W-1:1]};
            if (cnt_ff == '0) begin
               rem_in   = '0;
               cnt_in   = CNT_W'(PROD_W - 1);
               state_in = U_DIV;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         U_DIV: begin
            // restoring step: quotient bits fill the product from the bottom
            rem_in  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            prod_in = {prod_ff[PROD_W-2:0], ge};
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      prod_ff <= prod_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
   end

   assign busy = state_ff != U_IDLE;
   assign done = done_ff;
   // zero divisor gives zero elapsed time
   assign quot = (den_ff == '0) ? '0 : prod_ff[TIME_W-1:0];

endmodule

`default_nettype wire

@@ hdl/rate_scaled_playback_clock_core.sv @@
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    rspc_pkg::req_type req_data
// rsp      out        rsp_valid/rsp_ready    rspc_pkg::rsp_type rsp_data
// csr      in         csr_we (no wait)       csr_index, csr_wdata
//
// Tick, set time, play, an unchanged play flag, a speed set while paused or unchanged,
// a paused or benchmark read and invalid codes answer in the cycle after the accepting edge;
// one such beat per cycle while rsp is taken.
// A read while playing, a speed change while playing and a pause run the shared muldiv:
// bit-serial multiply of the elapsed ticks and restoring divide of the TIME_W + NUM_W bit
// product; the response is registered once muldiv signals done. Reset is synchronous
// and needs no clearing pass.
// A stalled rsp holds req_ready low.

module rate_scaled_playback_clock_core #(
   parameter int TICKS_PER_SEC = rspc_pkg::TICKS_PER_SEC_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire rspc_pkg::req_type              req_data,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      rspc_pkg::rsp_type              rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [rspc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rspc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rspc_pkg::*;

   localparam int NUM_W = SPEED_W + $clog2(TICKS_PER_SEC + 1);

   typedef enum logic {S_IDLE, S_CALC} state_type;

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic                 status_ff, status_in;
   req_type              hold_ff, hold_in;

   logic [FREQ_W-1:0]    source_freq_ff, source_freq_in;
   logic [TIME_W-1:0]    bench_ff, bench_in;
   logic [TIME_W-1:0]    tick_now_ff, tick_now_in;
   logic                 playing_ff, playing_in;
   logic [SPEED_W-1:0]   speed_n_ff, speed_n_in;
   logic [SPEED_W-1:0]   speed_d_ff, speed_d_in;
   logic [NUM_W-1:0]     scaled_num_ff, scaled_num_in;
   logic [DEN_W-1:0]     scaled_den_ff, scaled_den_in;
   logic [TIME_W-1:0]    start_time_ff, start_time_in;
   logic [TIME_W-1:0]    ref_tick_ff, ref_tick_in;

   logic                 req_fire;
   logic                 speed_diff;
   req_type              spd_src;
   logic [NUM_W-1:0]     new_num;
   logic [DEN_W-1:0]     new_den;

   logic                 mdu_start;
   logic                 mdu_busy;
   logic                 mdu_done;
   logic [TIME_W-1:0]    mdu_quot;
   logic [TIME_W-1:0]    mdu_ticks;

   assign req_ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire   = req_valid && req_ready;
   assign mdu_ticks  = tick_now_ff - ref_tick_ff;
   assign speed_diff = (req_data.speed_num != speed_n_ff) || (req_data.speed_den != speed_d_ff);
   assign spd_src    = (state_ff == S_CALC) ? hold_ff : req_data;
   assign new_num    = NUM_W'(spd_src.speed_num) * NUM_W'(TICKS_PER_SEC);
   assign new_den    = DEN_W'(spd_src.speed_den) * DEN_W'(source_freq_ff);

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      now_in         = now_ff;
      status_in      = status_ff;
      hold_in        = hold_ff;
      source_freq_in = source_freq_ff;
      bench_in       = bench_ff;
      tick_now_in    = tick_now_ff;
      playing_in     = playing_ff;
      speed_n_in     = speed_n_ff;
      speed_d_in     = speed_d_ff;
      scaled_num_in  = scaled_num_ff;
      scaled_den_in  = scaled_den_ff;
      start_time_in  = start_time_ff;
      ref_tick_in    = ref_tick_ff;
      mdu_start      = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_SOURCE_FREQ:  source_freq_in = csr_wdata[FREQ_W-1:0];
            CSR_BENCH_MARKER: bench_in       = csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               hold_in      = req_data;
               now_in       = '0;
               status_in    = 1'b0;
               rsp_valid_in = 1'b1;
               case (req_data.func)
                  FUNC_TICK: tick_now_in = tick_now_ff + TIME_W'(1);
                  FUNC_READ: begin
                     if (speed_n_ff == '0) begin
                        now_in = bench_ff;
                     end else if (playing_ff) begin
                        mdu_start    = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = S_CALC;
                     end else begin
                        now_in = start_time_ff;
                     end
                  end
                  FUNC_SET_TIME: begin
                     start_time_in = req_data.time_value;
                     ref_tick_in   = tick_now_ff;
                  end
                  FUNC_SET_SPEED: begin
                     if (speed_diff && playing_ff) begin
                        // fold elapsed time before the speed changes
                        mdu_start    = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = S_CALC;
                     end else if (speed_diff) begin
                        speed_n_in    = req_data.speed_num;
                        speed_d_in    = req_data.speed_den;
                        scaled_num_in = new_num;
                        scaled_den_in = new_den;
                     end
                  end
                  FUNC_SET_PLAY: begin
                     if (req_data.play_value != playing_ff) begin
                        if (playing_ff) begin
                           mdu_start    = 1'b1;
                           rsp_valid_in = 1'b0;
                           state_in     = S_CALC;
                        end else begin
                           playing_in  = 1'b1;
                           ref_tick_in = tick_now_ff;
                        end
                     end
                  end
                  default: status_in = 1'b1;
               endcase
            end
         end
         S_CALC: begin
            if (mdu_done) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               case (hold_ff.func)
                  FUNC_READ: now_in = start_time_ff + mdu_quot;
                  FUNC_SET_SPEED: begin
                     start_time_in = start_time_ff + mdu_quot;
                     ref_tick_in   = tick_now_ff;
                     speed_n_in    = hold_ff.speed_num;
                     speed_d_in    = hold_ff.speed_den;
                     scaled_num_in = new_num;
                     scaled_den_in = new_den;
                  end
                  FUNC_SET_PLAY: begin
                     start_time_in = start_time_ff + mdu_quot;
                     ref_tick_in   = tick_now_ff;
                     playing_in    = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         source_freq_ff <= SRC_FREQ_RST;
         bench_ff       <= BENCH_MARKER_RST;
         tick_now_ff    <= '0;
         playing_ff     <= 1'b0;
         speed_n_ff     <= SPEED_W'(1);
         speed_d_ff     <= SPEED_W'(1);
         scaled_num_ff  <= NUM_W'(TICKS_PER_SEC);
         scaled_den_ff  <= DEN_W'(SRC_FREQ_RST);
         start_time_ff  <= '0;
         ref_tick_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         source_freq_ff <= source_freq_in;
         bench_ff       <= bench_in;
         tick_now_ff    <= tick_now_in;
         playing_ff     <= playing_in;
         speed_n_ff     <= speed_n_in;
         speed_d_ff     <= speed_d_in;
         scaled_num_ff  <= scaled_num_in;
         scaled_den_ff  <= scaled_den_in;
         start_time_ff  <= start_time_in;
         ref_tick_ff    <= ref_tick_in;
      end
      now_ff    <= now_in;
      status_ff <= status_in;
      hold_ff   <= hold_in;
   end

   rspc_muldiv #(
      .NUM_W(NUM_W)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (mdu_start),
      .ticks (mdu_ticks),
      .num   (scaled_num_ff),
      .den   (scaled_den_ff),
      .busy  (mdu_busy),
      .done  (mdu_done),
      .quot  (mdu_quot)
   );

   // speed and play flag come straight from state; it holds while rsp waits
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.now_time      = now_ff;
   assign rsp_data.play_state    = playing_ff;
   assign rsp_data.cur_speed_num = speed_n_ff;
   assign rsp_data.cur_speed_den = speed_d_ff;
   assign rsp_data.status        = status_ff;

   a_calc_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CALC |-> !rsp_valid_ff)
      else $error("response pending while muldiv runs");

   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CALC && mdu_done) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("muldiv result not delivered");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      mdu_start |-> !mdu_busy)
      else $error("muldiv started while busy");

   a_rsp_state_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=>
         ($stable(playing_ff) && $stable(speed_n_ff) && $stable(speed_d_ff)))
      else $error("state moved under a stalled response");

endmodule

`default_nettype wire
